FILE: rtl/core/iwmd_pkg.sv
// Package for the interface solvent minimum-distance block.
// Shared types, constants and opcodes; no dependencies.
`default_nettype none
package iwmd_pkg;
   localparam int MaxAtoms   = 4096;
   localparam int MaxSolvent = 1024;
   localparam int FracBits   = 8;
   localparam int AccWidth   = 40;
   localparam int AtomAw     = $clog2(MaxAtoms);
   localparam int SlotAw     = $clog2(MaxSolvent);
   localparam int FillW      = AtomAw + 1;
   localparam int CoordW     = 24;
   localparam int DiffW      = CoordW + 1;
   localparam int SqW        = 2 * DiffW;
   localparam int DistW      = SqW + 2;
   localparam int RootW      = DistW / 2;
   localparam logic [DistW-1:0] CapSq = DistW'(400) << (2 * FracBits);
   localparam logic [AccWidth-1:0] AccMax = '1;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_ROOT,
      ST_ACC_RD,
      ST_ACC_WR
   } state_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } point_type;

   typedef struct packed {
      logic             start;
      logic [DistW-1:0] value;
   } root_req_type;
endpackage
`default_nettype wire

FILE: rtl/core/iwmd_sqrt.sv
// Bit-serial floor square root, one result bit per cycle.
// Depends on iwmd_pkg.
`default_nettype none
module iwmd_sqrt import iwmd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire root_req_type       req,
   output logic                    done,
   output logic [RootW-1:0]        root
);
   logic [DistW-1:0] rem_ff, rem_in;
   logic [DistW-1:0] val_ff, val_in;
   logic [RootW-1:0] res_ff, res_in;
   logic [$clog2(RootW+1)-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [DistW-1:0] trial;
   logic [DistW-1:0] rem_sh;
   logic [DistW-1:0] rem_nx;
   logic [RootW-1:0] res_nx;
   logic last;

   // one restoring step on the current remainder
   always_comb begin
      rem_sh = {rem_ff[DistW-3:0], val_ff[DistW-1 -: 2]};
      trial  = DistW'({res_ff, 2'b01});
      if (rem_sh >= trial) begin
         rem_nx = rem_sh - trial;
         res_nx = {res_ff[RootW-2:0], 1'b1};
      end else begin
         rem_nx = rem_sh;
         res_nx = {res_ff[RootW-2:0], 1'b0};
      end
   end

   assign last = (cnt_ff == ($clog2(RootW+1))'(RootW - 1));

   always_comb begin
      rem_in  = rem_ff;
      val_in  = val_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (req.start) begin
         rem_in  = '0;
         val_in  = req.value;
         res_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in = {val_ff[DistW-3:0], 2'b00};
         rem_in = rem_nx;
         res_in = res_nx;
         cnt_in = cnt_ff + 1'b1;
         if (last) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      val_ff <= val_in;
      res_ff <= res_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   // done marks the cycle of the last step; a new start may follow at once
   assign done = busy_ff && last;
   assign root = res_nx;
endmodule
`default_nettype wire

FILE: rtl/core/iwmd_scan.sv
// Atom stores and the nearest-atom scan, both sides in parallel.
// Depends on iwmd_pkg.
`default_nettype none
module iwmd_scan import iwmd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic             wr_side,
   input  wire logic [AtomAw-1:0] wr_addr,
   input  wire point_type        wr_data,
   input  wire logic             scan_start,
   input  wire point_type        probe,
   input  wire logic [FillW-1:0] fill_a,
   input  wire logic [FillW-1:0] fill_b,
   output logic                  scan_done,
   output logic [DistW-1:0]      min_a,
   output logic [DistW-1:0]      min_b
);
   point_type mem_a [MaxAtoms];
   point_type mem_b [MaxAtoms];
   point_type rd_a_ff, rd_b_ff;
   logic [FillW-1:0] idx_ff, idx_in;
   logic run_ff, run_in;
   logic v1a_ff, v1b_ff;
   logic v2a_ff, v2b_ff;
   logic [SqW-1:0] sa_ff [3];
   logic [SqW-1:0] sb_ff [3];
   logic [DistW-1:0] min_a_ff, min_b_ff;
   logic fin1_ff, fin2_ff, fin3_ff;
   logic [DistW-1:0] da, db;

   function automatic logic [SqW-1:0] sq(input logic signed [CoordW-1:0] p,
                                         input logic signed [CoordW-1:0] q);
      logic signed [DiffW-1:0] d;
      logic [DiffW-1:0] m;
      d = DiffW'(p) - DiffW'(q);
      m = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
      return m * m;
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en && !wr_side) mem_a[wr_addr] <= wr_data;
      if (wr_en && wr_side)  mem_b[wr_addr] <= wr_data;
      rd_a_ff <= mem_a[idx_ff[AtomAw-1:0]];
      rd_b_ff <= mem_b[idx_ff[AtomAw-1:0]];
   end

   always_comb begin
      idx_in = idx_ff;
      run_in = run_ff;
      if (scan_start) begin
         idx_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == FillW'(MaxAtoms - 1)) run_in = 1'b0;
      end
   end

   assign da = DistW'(sa_ff[0]) + DistW'(sa_ff[1]) + DistW'(sa_ff[2]);
   assign db = DistW'(sb_ff[0]) + DistW'(sb_ff[1]) + DistW'(sb_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         v1a_ff  <= 1'b0;
         v1b_ff  <= 1'b0;
         v2a_ff  <= 1'b0;
         v2b_ff  <= 1'b0;
         fin1_ff <= 1'b0;
         fin2_ff <= 1'b0;
         fin3_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         // stage 1: memory read
         v1a_ff  <= run_ff && (idx_ff < fill_a);
         v1b_ff  <= run_ff && (idx_ff < fill_b);
         fin1_ff <= run_ff && !run_in;
         // stage 2: squares
         v2a_ff  <= v1a_ff;
         v2b_ff  <= v1b_ff;
         fin2_ff <= fin1_ff;
         // stage 3: sum and compare
         fin3_ff <= fin2_ff;
      end
      idx_ff <= idx_in;
      sa_ff[0] <= sq(probe.x, rd_a_ff.x);
      sa_ff[1] <= sq(probe.y, rd_a_ff.y);
      sa_ff[2] <= sq(probe.z, rd_a_ff.z);
      sb_ff[0] <= sq(probe.x, rd_b_ff.x);
      sb_ff[1] <= sq(probe.y, rd_b_ff.y);
      sb_ff[2] <= sq(probe.z, rd_b_ff.z);
      if (scan_start) begin
         min_a_ff <= CapSq;
         min_b_ff <= CapSq;
      end else begin
         if (v2a_ff && da < min_a_ff) min_a_ff <= da;
         if (v2b_ff && db < min_b_ff) min_b_ff <= db;
      end
   end

   assign scan_done = fin3_ff;
   assign min_a = min_a_ff;
   assign min_b = min_b_ff;
endmodule
`default_nettype wire

FILE: rtl/core/iwmd_acc.sv
// Per-solvent accumulator memory with saturating add.
// Depends on iwmd_pkg.
`default_nettype none
module iwmd_acc import iwmd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              clr_en,
   input  wire logic [SlotAw-1:0] clr_addr,
   input  wire logic [SlotAw-1:0] addr,
   input  wire logic              wr_en,
   input  wire logic [RootW-1:0]  add_a,
   input  wire logic [RootW-1:0]  add_b,
   input  wire logic [RootW-1:0]  add_d,
   output logic [AccWidth-1:0]    sum_a,
   output logic [AccWidth-1:0]    sum_b,
   output logic [AccWidth-1:0]    sum_d
);
   logic [3*AccWidth-1:0] mem [MaxSolvent];
   logic [3*AccWidth-1:0] rd_ff;

   function automatic logic [AccWidth-1:0] sat(input logic [AccWidth-1:0] a,
                                               input logic [RootW-1:0] v);
      logic [AccWidth:0] s;
      s = {1'b0, a} + (AccWidth+1)'(v);
      return s[AccWidth] ? AccMax : s[AccWidth-1:0];
   endfunction

   assign sum_a = sat(rd_ff[3*AccWidth-1 -: AccWidth], add_a);
   assign sum_b = sat(rd_ff[2*AccWidth-1 -: AccWidth], add_b);
   assign sum_d = sat(rd_ff[AccWidth-1:0], add_d);

   always_ff @(posedge clock) begin
      if (clr_en) mem[clr_addr] <= '0;
      else if (wr_en) mem[addr] <= {sum_a, sum_b, sum_d};
      rd_ff <= mem[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/interface_water_min_distance.sv
// Usage:
// Command port: drive req_* with start high; the item is taken on an edge
// where start is high and busy is low. op 0 clears both atom stores, op 1
// loads one atom (only interface atoms, dropped once a side holds 4096),
// op 2 queries a solvent. Clear and load leave the block idle.
// A query scans all 4096 entries of both side stores in parallel, one entry
// per cycle, set by the single read port of each atom memory; then three
// bit-serial square roots in turn and a read-modify-write of the
// accumulator memory. Busy stays high through the whole query, so queries
// do not overlap; the next command can be taken in the cycle in which the
// result shows. The result appears on rsp_* for exactly one cycle with
// rsp_valid high; the receiver cannot stall it. After reset the block runs a
// clearing pass over the 1024 accumulator entries with busy high before it
// takes any command. Reset empties both atom stores.
`default_nettype none
module interface_water_min_distance import iwmd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_op,
   input  wire logic                 req_side,
   input  wire logic                 req_in_interface,
   input  wire logic signed [23:0]   req_pos_x,
   input  wire logic signed [23:0]   req_pos_y,
   input  wire logic signed [23:0]   req_pos_z,
   input  wire logic [9:0]           req_solvent_slot,
   input  wire logic signed [23:0]   req_start_x,
   input  wire logic signed [23:0]   req_start_y,
   input  wire logic signed [23:0]   req_start_z,
   output logic                      rsp_valid,
   output logic [9:0]                rsp_slot_out,
   output logic [12:0]               rsp_near_a,
   output logic [12:0]               rsp_near_b,
   output logic [24:0]               rsp_drift,
   output logic [39:0]               rsp_sum_a,
   output logic [39:0]               rsp_sum_b,
   output logic [39:0]               rsp_sum_drift
);
   state_type state_ff, state_in;
   logic [FillW-1:0] fill_ff [2];
   logic [SlotAw:0] clr_ff;
   point_type pos_ff, st_ff;
   logic [SlotAw-1:0] slot_ff;
   logic [1:0] root_sel_ff;
   logic [RootW-1:0] near_a_ff, near_b_ff, drift_ff;
   logic take, scan_start, scan_done, root_done, load_ok;
   logic [DistW-1:0] min_a, min_b, drift_sq;
   logic [RootW-1:0] root;
   root_req_type root_req;
   logic [AccWidth-1:0] sum_a, sum_b, sum_d;
   logic rsp_ff;
   logic [SqW-1:0] dx, dy, dz;

   function automatic logic [SqW-1:0] sq(input logic signed [CoordW-1:0] p,
                                         input logic signed [CoordW-1:0] q);
      logic signed [DiffW-1:0] d;
      logic [DiffW-1:0] m;
      d = DiffW'(p) - DiffW'(q);
      m = d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
      return m * m;
   endfunction

   assign busy = (state_ff != ST_IDLE);
   assign take = start && !busy;
   assign load_ok = take && op_type'(req_op) == OP_LOAD && req_in_interface
                    && fill_ff[req_side] < FillW'(MaxAtoms);
   assign scan_start = take && op_type'(req_op) == OP_QUERY;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_ff == (SlotAw+1)'(MaxSolvent - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (scan_start) state_in = ST_SCAN;
         ST_SCAN:   if (scan_done) state_in = ST_ROOT;
         ST_ROOT:   if (root_done && root_sel_ff == 2'd2) state_in = ST_ACC_RD;
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign dx = sq(pos_ff.x, st_ff.x);
   assign dy = sq(pos_ff.y, st_ff.y);
   assign dz = sq(pos_ff.z, st_ff.z);
   assign drift_sq = DistW'(dx) + DistW'(dy) + DistW'(dz);

   always_comb begin
      root_req.start = 1'b0;
      root_req.value = min_a;
      if (state_ff == ST_SCAN && scan_done) root_req.start = 1'b1;
      else if (state_ff == ST_ROOT && root_done && root_sel_ff != 2'd2) begin
         root_req.start = 1'b1;
         root_req.value = (root_sel_ff == 2'd0) ? min_b : drift_sq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         fill_ff[0] <= '0;
         fill_ff[1] <= '0;
         rsp_ff <= 1'b0;
         root_sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_ff <= (state_ff == ST_ACC_WR);
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (take && op_type'(req_op) == OP_CLEAR) begin
            fill_ff[0] <= '0;
            fill_ff[1] <= '0;
         end
         if (load_ok) fill_ff[req_side] <= fill_ff[req_side] + 1'b1;
         if (scan_start) root_sel_ff <= '0;
         else if (state_ff == ST_ROOT && root_done) root_sel_ff <= root_sel_ff + 1'b1;
      end
      if (scan_start) begin
         pos_ff  <= '{req_pos_x, req_pos_y, req_pos_z};
         st_ff   <= '{req_start_x, req_start_y, req_start_z};
         slot_ff <= req_solvent_slot;
      end
      if (state_ff == ST_ROOT && root_done) begin
         if (root_sel_ff == 2'd0) near_a_ff <= root;
         if (root_sel_ff == 2'd1) near_b_ff <= root;
         if (root_sel_ff == 2'd2) drift_ff <= root;
      end
      if (state_ff == ST_ACC_WR) begin
         rsp_sum_a <= sum_a;
         rsp_sum_b <= sum_b;
         rsp_sum_drift <= sum_d;
      end
   end

   iwmd_scan u_scan (
      .clock(clock), .reset(reset), .wr_en(load_ok), .wr_side(req_side),
      .wr_addr(fill_ff[req_side][AtomAw-1:0]),
      .wr_data({req_pos_x, req_pos_y, req_pos_z}),
      .scan_start(scan_start), .probe(pos_ff),
      .fill_a(fill_ff[0]), .fill_b(fill_ff[1]),
      .scan_done(scan_done), .min_a(min_a), .min_b(min_b)
   );

   iwmd_sqrt u_sqrt (
      .clock(clock), .reset(reset), .req(root_req), .done(root_done), .root(root)
   );

   iwmd_acc u_acc (
      .clock(clock), .clr_en(state_ff == ST_CLEAR), .clr_addr(clr_ff[SlotAw-1:0]),
      .addr(slot_ff), .wr_en(state_ff == ST_ACC_WR),
      .add_a(near_a_ff), .add_b(near_b_ff), .add_d(drift_ff),
      .sum_a(sum_a), .sum_b(sum_b), .sum_d(sum_d)
   );

   assign rsp_valid = rsp_ff;
   assign rsp_slot_out = slot_ff;
   assign rsp_near_a = near_a_ff[12:0];
   assign rsp_near_b = near_b_ff[12:0];
   assign rsp_drift = drift_ff[24:0];
endmodule
`default_nettype wire

FILE: dv/iwmd_checker.sv
// Checker for interface_water_min_distance: watches the command and result ports,
// predicts every query result and compares it field by field.
// Depends on iwmd_pkg for opcodes and sizes.
`timescale 1ns / 100ps
module iwmd_checker import iwmd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [1:0]         req_op,
   input  wire logic               req_side,
   input  wire logic               req_in_interface,
   input  wire logic signed [23:0] req_pos_x,
   input  wire logic signed [23:0] req_pos_y,
   input  wire logic signed [23:0] req_pos_z,
   input  wire logic [9:0]         req_solvent_slot,
   input  wire logic signed [23:0] req_start_x,
   input  wire logic signed [23:0] req_start_y,
   input  wire logic signed [23:0] req_start_z,
   input  wire logic               rsp_valid,
   input  wire logic [9:0]         rsp_slot_out,
   input  wire logic [12:0]        rsp_near_a,
   input  wire logic [12:0]        rsp_near_b,
   input  wire logic [24:0]        rsp_drift,
   input  wire logic [39:0]        rsp_sum_a,
   input  wire logic [39:0]        rsp_sum_b,
   input  wire logic [39:0]        rsp_sum_drift,
   output int                      errors,
   output int                      pending
);
   typedef struct {
      logic [9:0]  slot;
      logic [12:0] near_a;
      logic [12:0] near_b;
      logic [24:0] drift;
      logic [39:0] sum_a;
      logic [39:0] sum_b;
      logic [39:0] sum_drift;
   } distance_result;

   int                 atom_x[2][MaxAtoms];
   int                 atom_y[2][MaxAtoms];
   int                 atom_z[2][MaxAtoms];
   int                 fill_cnt[2];
   longint unsigned    near_sum[2][MaxSolvent];
   longint unsigned    drift_sum[MaxSolvent];
   distance_result     expected_q[$];

   function automatic longint unsigned dist_sq(int ax, int ay, int az, int bx, int by, int bz);
      longint dx, dy, dz;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      dz = longint'(az) - longint'(bz);
      return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
   endfunction

   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned root, probe;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         probe = root | (64'd1 << b);
         if (probe * probe <= v)
            root = probe;
      end
      return root;
   endfunction

   function automatic longint unsigned sat_add(longint unsigned acc, longint unsigned v);
      longint unsigned s;
      s = acc + v;
      if (s > longint'(AccMax))
         return longint'(AccMax);
      return s;
   endfunction

   task automatic check(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   function automatic distance_result predict_query();
      distance_result r;
      longint unsigned best[2];
      longint unsigned d, dr;
      int px, py, pz, slot;
      px = req_pos_x;
      py = req_pos_y;
      pz = req_pos_z;
      slot = req_solvent_slot;
      for (int s = 0; s < 2; s++) begin
         best[s] = longint'(CapSq);
         for (int k = 0; k < fill_cnt[s]; k++) begin
            d = dist_sq(px, py, pz, atom_x[s][k], atom_y[s][k], atom_z[s][k]);
            if (d < best[s])
               best[s] = d;
         end
         best[s] = isqrt(best[s]);
         near_sum[s][slot] = sat_add(near_sum[s][slot], best[s]);
      end
      dr = isqrt(dist_sq(px, py, pz, req_start_x, req_start_y, req_start_z));
      drift_sum[slot] = sat_add(drift_sum[slot], dr);
      r.slot = req_solvent_slot;
      r.near_a = best[0][12:0];
      r.near_b = best[1][12:0];
      r.drift = dr[24:0];
      r.sum_a = near_sum[0][slot][39:0];
      r.sum_b = near_sum[1][slot][39:0];
      r.sum_drift = drift_sum[slot][39:0];
      return r;
   endfunction

   always @(posedge clock) begin
      distance_result e;
      if (reset) begin
         fill_cnt[0] = 0;
         fill_cnt[1] = 0;
         for (int i = 0; i < MaxSolvent; i++) begin
            near_sum[0][i] = 0;
            near_sum[1][i] = 0;
            drift_sum[i] = 0;
         end
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result for slot %0d", $time, rsp_slot_out);
            end else begin
               e = expected_q.pop_front();
               check("slot_out", e.slot, rsp_slot_out);
               check("near_a", e.near_a, rsp_near_a);
               check("near_b", e.near_b, rsp_near_b);
               check("drift", e.drift, rsp_drift);
               check("sum_a", e.sum_a, rsp_sum_a);
               check("sum_b", e.sum_b, rsp_sum_b);
               check("sum_drift", e.sum_drift, rsp_sum_drift);
            end
         end
         if (start && !busy) begin
            case (op_type'(req_op))
               OP_CLEAR: begin
                  fill_cnt[0] = 0;
                  fill_cnt[1] = 0;
               end
               OP_LOAD: begin
                  if (req_in_interface && fill_cnt[req_side] < MaxAtoms) begin
                     atom_x[req_side][fill_cnt[req_side]] = req_pos_x;
                     atom_y[req_side][fill_cnt[req_side]] = req_pos_y;
                     atom_z[req_side][fill_cnt[req_side]] = req_pos_z;
                     fill_cnt[req_side]++;
                  end
               end
               OP_QUERY: begin
                  if (req_solvent_slot < MaxSolvent)
                     expected_q.push_back(predict_query());
               end
               default: ;
            endcase
         end
      end
      pending <= expected_q.size();
   end

   initial begin
      errors = 0;
   end
endmodule

FILE: dv/interface_water_min_distance_tb.sv
// Top of the testbench for interface_water_min_distance: clock, reset, command
// stimulus and verdict. Depends on iwmd_pkg, the block and iwmd_checker.
`timescale 1ns / 100ps
module interface_water_min_distance_tb;
   import iwmd_pkg::*;

   localparam int CycleLimit = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_op = OP_NONE;
   logic               req_side = 1'b0;
   logic               req_in_interface = 1'b0;
   logic signed [23:0] req_pos_x = '0;
   logic signed [23:0] req_pos_y = '0;
   logic signed [23:0] req_pos_z = '0;
   logic [9:0]         req_solvent_slot = '0;
   logic signed [23:0] req_start_x = '0;
   logic signed [23:0] req_start_y = '0;
   logic signed [23:0] req_start_z = '0;
   logic               rsp_valid;
   logic [9:0]         rsp_slot_out;
   logic [12:0]        rsp_near_a;
   logic [12:0]        rsp_near_b;
   logic [24:0]        rsp_drift;
   logic [39:0]        rsp_sum_a;
   logic [39:0]        rsp_sum_b;
   logic [39:0]        rsp_sum_drift;
   int                 errors;
   int                 pending;
   int                 cycles = 0;

   // solvent cluster center for the random part
   int cx, cy, cz;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   interface_water_min_distance dut (.*);

   iwmd_checker chk (.*);

   // one transfer; start stays high on return
   task automatic send(op_type op, int side, int intf, int px, int py, int pz,
                       int slot, int sx, int sy, int sz);
      start <= 1'b1;
      req_op <= op;
      req_side <= side[0];
      req_in_interface <= intf[0];
      req_pos_x <= px[23:0];
      req_pos_y <= py[23:0];
      req_pos_z <= pz[23:0];
      req_solvent_slot <= slot[9:0];
      req_start_x <= sx[23:0];
      req_start_y <= sy[23:0];
      req_start_z <= sz[23:0];
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle();
      int r, n;
      r = $urandom_range(0, 19);
      if (r < 10) n = 0;
      else if (r < 18) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic int near_c(int c, int spread);
      return c + $signed($urandom_range(0, 2 * spread)) - spread;
   endfunction

   function automatic int any_c();
      return int'($signed($urandom() & 32'hFFFFFF) << 8) >>> 8;
   endfunction

   initial begin
      int n_items, slot;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty stores, extremes, ignored loads, ties, unused opcode
      send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(OP_QUERY, 1, 1, -8388608, -8388608, -8388608, 1023,
           8388607, 8388607, 8388607);
      send(OP_LOAD, 0, 0, 100, 100, 100, 0, 0, 0, 0);
      send(OP_LOAD, 0, 1, 8388607, 8388607, 8388607, 0, 0, 0, 0);
      send(OP_LOAD, 1, 1, -8388608, -8388608, -8388608, 0, 0, 0, 0);
      send(OP_LOAD, 0, 1, 256, 0, 0, 0, 0, 0, 0);
      send(OP_LOAD, 0, 1, -256, 0, 0, 0, 0, 0, 0);
      send(OP_LOAD, 1, 1, 0, 5120, 0, 0, 0, 0, 0);
      send(OP_LOAD, 1, 1, 0, 0, 5119, 0, 0, 0, 0);
      idle();
      send(OP_QUERY, 0, 0, 0, 0, 0, 5, 0, 0, 0);
      send(OP_QUERY, 0, 0, 8388607, 8388607, 8388600, 5, -8388608, -8388608, -8388608);
      send(OP_QUERY, 1, 1, -8388608, -8388608, -8388608, 1023, 0, 0, 0);
      send(OP_NONE, 1, 1, 1, 1, 1, 5, 1, 1, 1);
      send(OP_QUERY, 0, 0, 0, 0, 0, 5, 0, 0, 0);
      send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send(OP_QUERY, 0, 0, 0, 0, 0, 5, 1, 2, 3);

      // random frames: clear, a cluster of atoms, queries around it, some noise
      n_items = 0;
      while (n_items < 120) begin
         cx = any_c();
         cy = any_c();
         cz = any_c();
         send(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
         idle();
         n_items++;
         repeat ($urandom_range(2, 12)) begin
            if ($urandom_range(0, 9) == 0)
               send(OP_LOAD, $urandom_range(0, 1), $urandom_range(0, 1),
                    any_c(), any_c(), any_c(), $urandom(), any_c(), any_c(), any_c());
            else
               send(OP_LOAD, $urandom_range(0, 1), int'($urandom_range(0, 7) != 0),
                    near_c(cx, 6000), near_c(cy, 6000), near_c(cz, 6000),
                    $urandom(), any_c(), any_c(), any_c());
            idle();
            n_items++;
         end
         repeat ($urandom_range(1, 4)) begin
            slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 3);
            case ($urandom_range(0, 5))
               0: send(OP_QUERY, $urandom(), $urandom(), any_c(), any_c(), any_c(),
                       slot, any_c(), any_c(), any_c());
               1: send(OP_NONE, $urandom(), $urandom(), any_c(), any_c(), any_c(),
                       $urandom(), any_c(), any_c(), any_c());
               default: send(OP_QUERY, $urandom(), $urandom(),
                             near_c(cx, 5000), near_c(cy, 5000), near_c(cz, 5000), slot,
                             near_c(cx, 20000), near_c(cy, 20000), near_c(cz, 20000));
            endcase
            idle();
            n_items++;
         end
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/core/iwmd_pkg.sv
rtl/core/iwmd_sqrt.sv
rtl/core/iwmd_scan.sv
rtl/core/iwmd_acc.sv
rtl/core/interface_water_min_distance.sv
dv/iwmd_checker.sv
dv/interface_water_min_distance_tb.sv
